/* design/vna_pkg.sv */
// Package for the vertex normal averaging unit: word types, field widths,
// item kinds, sequencer states and the edge reduction helper. No dependencies.
`default_nettype none
package vna_pkg;

	localparam int VERTEX_SLOTS_DEF = 1024;
	localparam int IDX_BITS         = 10;
	localparam int COORD_BITS       = 24;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORM_BITS        = 16;
	localparam int SUM_BITS         = 26;
	localparam int COUNT_BITS       = 8;
	localparam int EDGE_SHIFT       = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
	localparam int POS_W            = 3 * COORD_BITS;
	localparam int SUM_ENTRY_W      = 3 * SUM_BITS + COUNT_BITS;

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_FACE    = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;
	localparam logic [1:0] KIND_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic [IDX_BITS-1:0] vertex_index;
		logic signed [23:0]  pos_x;
		logic signed [23:0]  pos_y;
		logic signed [23:0]  pos_z;
		logic [IDX_BITS-1:0] corner_a;
		logic [IDX_BITS-1:0] corner_b;
		logic [IDX_BITS-1:0] corner_c;
	} cmd_word_t;

	typedef struct packed {
		logic signed [NORM_BITS-1:0] normal_x;
		logic signed [NORM_BITS-1:0] normal_y;
		logic signed [NORM_BITS-1:0] normal_z;
		logic [COUNT_BITS-1:0]       faces_touching;
		logic                        no_normal;
	} rsp_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POS,
		ST_EDGE,
		ST_MUL,
		ST_MAG,
		ST_MAX,
		ST_NORM,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_ACC,
		ST_SUM_RD,
		ST_OUT
	} state_t;

	// Edge magnitude is truncated toward zero when coordinates are wide.
	function automatic logic signed [31:0] edge_reduce(input logic signed [COORD_BITS:0] d);
		logic [COORD_BITS:0] mag;
		logic [COORD_BITS:0] red;
		mag = d[COORD_BITS] ? -d : d;
		red = mag >> EDGE_SHIFT;
		return d[COORD_BITS] ? -$signed(32'(red)) : $signed(32'(red));
	endfunction

endpackage
`default_nettype wire

/* design/vna_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Uses no package.
`default_nettype none
module vna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* design/vertex_normal_averaging_unit.sv */
// Vertex normal averaging unit: position table, normal sum table and a shared
// multiply / square root / divide sequencer. Depends on vna_pkg and vna_ram.
//
//   channel | direction | handshake          | word
//   cmd     | in        | cmd_valid/cmd_stall | cmd_word_t (load, face, read)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_word_t (one per read)
//
// A load is written in the cycle that takes it. A face and a read run through
// the sequencer, which shifts the largest magnitude one bit a step until it is
// normalized. The single 32x32 multiplier, the one-bit-a-cycle square root
// (32 steps) and the restoring divider (NORMAL_FRAC_BITS+4 steps per component)
// set their pace. After reset the sum table is swept to zero, one entry a cycle,
// until every entry is cleared, and cmd_stall stays high.
// A finished read word waits in the output register while rsp_stall holds.
`default_nettype none
module vertex_normal_averaging_unit
	import vna_pkg::*;
#(
	parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_word_t cmd,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);
	localparam int AW = $clog2(VERTEX_SLOTS);
	localparam int F  = NORMAL_FRAC_BITS;

	// Sequencer state. step_q counts cycles inside a state, comp_q walks the
	// three components or the three corners.
	state_t     state_q, state_d;
	logic [5:0] step_q, step_d;
	logic [1:0] comp_q, comp_d;
	logic       is_read_q;
	logic [AW-1:0] clr_q;
	logic       rsp_valid_q;

	// Item and datapath registers.
	cmd_word_t               cmd_q;
	logic [POS_W-1:0]        pa_q, pb_q, pc_q;
	logic signed [31:0]      e_q [3];
	logic signed [31:0]      f_q [3];
	logic signed [63:0]      prod_q, hold_q;
	logic signed [63:0]      v_q [3];
	logic [63:0]             m_q [3];
	logic [2:0]              sign_q;
	logic [63:0]             mx_q, sq_q, rn_q, res_q, num_q;
	logic [31:0]             rem_q;
	logic [F:0]              q_q;
	logic signed [NORM_BITS-1:0] nrm_q [3];
	logic [COUNT_BITS-1:0]   cnt_q;
	logic                    nok_q;
	rsp_word_t               rsp_q;

	// Memories.
	logic                   pos_we, sum_we;
	logic [AW-1:0]          pos_waddr, pos_raddr, sum_waddr, sum_raddr;
	logic [POS_W-1:0]       pos_wdata, pos_rdata;
	logic [SUM_ENTRY_W-1:0] sum_wdata, sum_rdata;

	vna_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_SLOTS)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rdata(pos_rdata)
	);

	vna_ram #(.WIDTH(SUM_ENTRY_W), .DEPTH(VERTEX_SLOTS)) u_sum_ram (
		.clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
		.raddr(sum_raddr), .rdata(sum_rdata)
	);

	// Decoded handshake and ranges.
	logic          cmd_take;
	logic          idx_ok, face_ok;
	logic [AW-1:0] corner_addr;
	logic          out_free;

	assign cmd_take  = cmd_valid && !cmd_stall;
	assign idx_ok    = 32'(cmd.vertex_index) < VERTEX_SLOTS;
	assign face_ok   = (32'(cmd.corner_a) < VERTEX_SLOTS) && (32'(cmd.corner_b) < VERTEX_SLOTS)
		&& (32'(cmd.corner_c) < VERTEX_SLOTS);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		unique case (comp_q)
			2'd0:    corner_addr = AW'(cmd_q.corner_a);
			2'd1:    corner_addr = AW'(cmd_q.corner_b);
			default: corner_addr = AW'(cmd_q.corner_c);
		endcase
	end

	// Shared multiplier: cross product terms, then the three squares.
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_SQ) begin
			mul_a = $signed({1'b0, m_q[comp_q][30:0]});
			mul_b = $signed({1'b0, m_q[comp_q][30:0]});
		end else begin
			case (step_q)
				6'd0:    begin mul_a = e_q[1]; mul_b = f_q[2]; end
				6'd1:    begin mul_a = e_q[2]; mul_b = f_q[1]; end
				6'd2:    begin mul_a = e_q[2]; mul_b = f_q[0]; end
				6'd3:    begin mul_a = e_q[0]; mul_b = f_q[2]; end
				6'd4:    begin mul_a = e_q[0]; mul_b = f_q[1]; end
				default: begin mul_a = e_q[1]; mul_b = f_q[0]; end
			endcase
		end
	end
	assign mul_p = mul_a * mul_b;

	// Largest component magnitude, taken straight from the magnitude registers
	// so that the zero test in ST_MAX sees the current vector.
	logic [63:0] m_max;

	assign m_max = (m_q[0] > m_q[1]) ? ((m_q[0] > m_q[2]) ? m_q[0] : m_q[2])
		: ((m_q[1] > m_q[2]) ? m_q[1] : m_q[2]);

	// Square root step and divide step.
	logic [63:0] bitv, sq_try;
	logic [5:0]  div_bit;
	logic [32:0] div_try;
	logic [31:0] len;
	logic [F:0]  q_clamp;

	assign len     = res_q[31:0];
	assign bitv    = 64'd1 << (7'd64 - 7'({step_q, 1'b0}));
	assign sq_try  = res_q + bitv;
	assign div_bit = 6'(F + 2) - step_q;
	assign div_try = {rem_q, num_q[div_bit]};
	assign q_clamp = (q_q > (F+1)'(1 << F)) ? (F+1)'(1 << F) : q_q;

	// Saturating accumulate of one corner.
	logic signed [SUM_BITS:0]   acc_s [3];
	logic [SUM_BITS-1:0]        acc_new [3];
	logic [COUNT_BITS-1:0]      cnt_old;

	assign cnt_old = sum_rdata[COUNT_BITS-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_s[i] = {sum_rdata[COUNT_BITS + i*SUM_BITS + SUM_BITS - 1],
				sum_rdata[COUNT_BITS + i*SUM_BITS +: SUM_BITS]}
				+ (SUM_BITS+1)'(nrm_q[i]);
			if (!acc_s[i][SUM_BITS] && acc_s[i][SUM_BITS-1]) begin
				acc_new[i] = {1'b0, {(SUM_BITS-1){1'b1}}};
			end else if (acc_s[i][SUM_BITS] && !acc_s[i][SUM_BITS-1]) begin
				acc_new[i] = {1'b1, {(SUM_BITS-1){1'b0}}};
			end else begin
				acc_new[i] = acc_s[i][SUM_BITS-1:0];
			end
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= '0;
			comp_q      <= '0;
			clr_q       <= '0;
			is_read_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			comp_q  <= comp_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd_take) begin
				is_read_q <= (cmd.kind == KIND_READ);
			end
			if (state_q == ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Next state and memory controls.
	always_comb begin
		state_d   = state_q;
		step_d    = step_q + 1'b1;
		comp_d    = comp_q;
		cmd_stall = (state_q != ST_IDLE);
		pos_we    = 1'b0;
		pos_waddr = AW'(cmd.vertex_index);
		pos_wdata = {COORD_BITS'(cmd.pos_z), COORD_BITS'(cmd.pos_y), COORD_BITS'(cmd.pos_x)};
		pos_raddr = AW'(cmd_q.corner_a);
		sum_we    = 1'b0;
		sum_waddr = AW'(cmd.vertex_index);
		sum_wdata = '0;
		sum_raddr = AW'(cmd_q.vertex_index);

		unique case (state_q)
			ST_CLEAR: begin
				sum_we    = 1'b1;
				sum_waddr = clr_q;
				if (clr_q == AW'(VERTEX_SLOTS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				step_d = '0;
				comp_d = '0;
				if (cmd_take) begin
					unique case (cmd.kind)
						KIND_LOAD: begin
							pos_we = idx_ok;
							sum_we = idx_ok;
						end
						KIND_FACE: state_d = face_ok ? ST_POS : ST_IDLE;
						KIND_READ: state_d = idx_ok ? ST_SUM_RD : ST_OUT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_POS: begin
				case (step_q)
					6'd0:    pos_raddr = AW'(cmd_q.corner_a);
					6'd1:    pos_raddr = AW'(cmd_q.corner_b);
					default: pos_raddr = AW'(cmd_q.corner_c);
				endcase
				if (step_q == 6'd3) begin
					state_d = ST_EDGE;
				end
			end
			ST_EDGE: begin
				state_d = ST_MUL;
				step_d  = '0;
			end
			ST_MUL: begin
				if (step_q == 6'd6) begin
					state_d = ST_MAG;
				end
			end
			ST_MAG: state_d = ST_MAX;
			ST_MAX: begin
				step_d = '0;
				comp_d = '0;
				// A zero vector skips the normalization: a degenerate face
				// still adds its zero normal and bumps the counts, and a read
				// goes out with the no-normal flag still set.
				if (m_max == '0) begin
					state_d = is_read_q ? ST_OUT : ST_ACC;
				end else begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				step_d = '0;
				comp_d = '0;
				if (!(|mx_q[63:31]) && mx_q[30]) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (step_q < 6'd2) begin
					comp_d = comp_q + 1'b1;
				end
				if (step_q == 6'd3) begin
					state_d = ST_SQRT;
					step_d  = '0;
				end
			end
			ST_SQRT: begin
				comp_d = '0;
				if (step_q == 6'd32) begin
					state_d = ST_DIV;
					step_d  = '0;
				end
			end
			ST_DIV: begin
				if (step_q == 6'(F + 3)) begin
					step_d = '0;
					comp_d = comp_q + 1'b1;
					if (comp_q == 2'd2) begin
						comp_d  = '0;
						state_d = is_read_q ? ST_OUT : ST_ACC;
					end
				end
			end
			ST_ACC: begin
				sum_raddr = corner_addr;
				sum_waddr = corner_addr;
				sum_wdata = {acc_new[2], acc_new[1], acc_new[0],
					(cnt_old == '1) ? cnt_old : cnt_old + 1'b1};
				if (step_q == 6'd1) begin
					sum_we = 1'b1;
					step_d = '0;
					comp_d = comp_q + 1'b1;
					if (comp_q == 2'd2) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SUM_RD: begin
				if (step_q == 6'd1) begin
					state_d = (cnt_old == '0) ? ST_OUT : ST_MAG;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (cmd_take) begin
			cmd_q <= cmd;
			cnt_q <= '0;
			nok_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				nrm_q[i] <= '0;
			end
		end
		case (state_q)
			ST_POS: begin
				if (step_q == 6'd1) pa_q <= pos_rdata;
				if (step_q == 6'd2) pb_q <= pos_rdata;
				if (step_q == 6'd3) pc_q <= pos_rdata;
			end
			ST_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					e_q[i] <= edge_reduce(
						{pb_q[i*COORD_BITS + COORD_BITS - 1], pb_q[i*COORD_BITS +: COORD_BITS]}
						- {pa_q[i*COORD_BITS + COORD_BITS - 1], pa_q[i*COORD_BITS +: COORD_BITS]});
					f_q[i] <= edge_reduce(
						{pc_q[i*COORD_BITS + COORD_BITS - 1], pc_q[i*COORD_BITS +: COORD_BITS]}
						- {pa_q[i*COORD_BITS + COORD_BITS - 1], pa_q[i*COORD_BITS +: COORD_BITS]});
				end
			end
			ST_MUL: begin
				if (step_q != 6'd0) begin
					if (!step_q[0]) begin
						v_q[2'(step_q[2:1] - 2'd1)] <= hold_q - prod_q;
					end else begin
						hold_q <= prod_q;
					end
				end
			end
			ST_SUM_RD: begin
				if (step_q == 6'd1) begin
					cnt_q <= cnt_old;
					for (int i = 0; i < 3; i++) begin
						v_q[i] <= -64'($signed(sum_rdata[COUNT_BITS + i*SUM_BITS +: SUM_BITS]));
					end
				end
			end
			ST_MAG: begin
				for (int i = 0; i < 3; i++) begin
					sign_q[i] <= v_q[i][63];
					m_q[i]    <= v_q[i][63] ? 64'(-v_q[i]) : 64'(v_q[i]);
				end
			end
			ST_MAX: begin
				mx_q <= m_max;
			end
			ST_NORM: begin
				if (|mx_q[63:31]) begin
					mx_q <= mx_q >> 1;
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end else if (!mx_q[30]) begin
					mx_q <= mx_q << 1;
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				end
			end
			ST_SQ: begin
				if (step_q == 6'd0) begin
					sq_q <= '0;
				end else begin
					sq_q <= sq_q + 64'(prod_q);
				end
			end
			ST_SQRT: begin
				if (step_q == 6'd0) begin
					rn_q  <= sq_q;
					res_q <= '0;
				end else if (rn_q >= sq_try) begin
					rn_q  <= rn_q - sq_try;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			ST_DIV: begin
				if (step_q == 6'd0) begin
					num_q <= (m_q[comp_q] << F) + 64'(len >> 1);
				end else if (step_q == 6'd1) begin
					rem_q <= 32'(num_q >> (F + 1));
					q_q   <= '0;
				end else if (step_q == 6'(F + 3)) begin
					nrm_q[comp_q] <= sign_q[comp_q] ? -NORM_BITS'(q_clamp) : NORM_BITS'(q_clamp);
					if (comp_q == 2'd2) begin
						nok_q <= 1'b0;
					end
				end else if (div_try >= {1'b0, len}) begin
					rem_q <= 32'(div_try - {1'b0, len});
					q_q   <= {q_q[F-1:0], 1'b1};
				end else begin
					rem_q <= div_try[31:0];
					q_q   <= {q_q[F-1:0], 1'b0};
				end
			end
			ST_OUT: begin
				if (out_free) begin
					rsp_q.normal_x       <= nrm_q[0];
					rsp_q.normal_y       <= nrm_q[1];
					rsp_q.normal_z       <= nrm_q[2];
					rsp_q.faces_touching <= cnt_q;
					rsp_q.no_normal      <= nok_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQ |-> (mx_q[63:31] == '0) && mx_q[30])
		else $error("normalizing shift left the largest magnitude out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == 6'd0 && comp_q == 2'd0) |-> (res_q[63:32] == '0)
			&& (res_q[31:30] != 2'b00))
		else $error("square root length out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output state");

endmodule
`default_nettype wire
